// ===== design/ipid_pkg.sv =====
`timescale 1ns / 1ps
// package: shared types and constants of the integer pid controller
package ipid_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_DIVISOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd7;

  localparam int SP_W    = 16;
  localparam int LIM_W   = 32;
  localparam int GAIN_W  = 16;
  localparam int FB_W    = 10;
  localparam int MEAS_W  = 16;
  localparam int DT_W    = 16;
  localparam int DRIVE_W = 32;

  localparam int ERR_W   = 20;
  localparam int DER_W   = 21;
  localparam int INT_W   = 48;
  localparam int SUM_W   = 49;
  localparam int ACC_W   = 50;
  localparam int SPLIT   = 24;

  localparam int DIV_W    = 64;
  localparam int DIV_HALF = DIV_W / 2;
  localparam int DVS_W    = 16;
  localparam int CNT_W    = 6;
  localparam logic [CNT_W-1:0] STEPS_FULL = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0] STEPS_HALF = CNT_W'(DIV_HALF - 1);

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [DVS_W-1:0] PERCENT       = 16'd100;
  localparam logic [DVS_W-1:0] INTEG_DIV_RST = 16'd1;
  localparam logic [FB_W-1:0]  FEEDBACK_RST  = 10'd100;

  typedef struct packed {
    logic signed [SP_W-1:0]   setpoint;
    logic signed [LIM_W-1:0]  lower_limit;
    logic signed [LIM_W-1:0]  upper_limit;
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic [DVS_W-1:0]         integ_divisor;
    logic [FB_W-1:0]          feedback_gain;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic half;
  } div_req_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_SIGN
  } div_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FB_MUL,
    S_FB_DIV,
    S_FB_WAIT,
    S_INT_MUL,
    S_INT_ADD,
    S_INT_DIV,
    S_INT_WAIT,
    S_CLAMP_MUL,
    S_CLAMP_SET,
    S_DER_DIV,
    S_DER_WAIT,
    S_P_MUL,
    S_P_DIV,
    S_P_WAIT,
    S_I_MUL_HI,
    S_I_MUL_LO,
    S_I_SUM,
    S_I_DIV,
    S_I_WAIT,
    S_D_MUL,
    S_D_DIV,
    S_D_WAIT,
    S_SAT,
    S_OUT
  } core_state_t;

endpackage

// ===== design/ipid_div.sv =====
`timescale 1ns / 1ps
// module: shared signed divider, restoring, one quotient bit per cycle
module ipid_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ipid_pkg::div_req_t                     req,
  input  logic signed [ipid_pkg::DIV_W-1:0]      dividend,
  input  logic [ipid_pkg::DVS_W-1:0]             divisor,
  output logic                                   done,
  output logic signed [ipid_pkg::DIV_W-1:0]      quo
);

  ipid_pkg::div_state_t state, state_next;

  logic [ipid_pkg::DVS_W-1:0] rem;
  logic [ipid_pkg::DVS_W-1:0] dvs;
  logic [ipid_pkg::DIV_W-1:0] shreg;
  logic [ipid_pkg::CNT_W-1:0] cnt;
  logic                       neg;
  logic                       load, step, finish;
  logic [ipid_pkg::DIV_W-1:0] dividend_u;
  logic [ipid_pkg::DIV_W-1:0] mag;
  logic [ipid_pkg::DVS_W:0]   part;
  logic [ipid_pkg::DVS_W+1:0] diff;
  logic                       fits;

  assign dividend_u = dividend;
  assign mag  = dividend[ipid_pkg::DIV_W-1] ? (~dividend_u + 1'b1) : dividend_u;
  assign part = {rem, shreg[ipid_pkg::DIV_W-1]};
  assign diff = {1'b0, part} - {2'b00, dvs};
  assign fits = !diff[ipid_pkg::DVS_W+1];

  always_comb begin
    state_next = state;
    case (state)
      ipid_pkg::DIV_IDLE: begin
        if (req.start) state_next = ipid_pkg::DIV_RUN;
      end
      ipid_pkg::DIV_RUN: begin
        if (cnt == '0) state_next = ipid_pkg::DIV_SIGN;
      end
      ipid_pkg::DIV_SIGN: begin
        state_next = ipid_pkg::DIV_IDLE;
      end
      default: begin
        state_next = ipid_pkg::DIV_IDLE;
      end
    endcase
  end

  always_comb begin
    load   = 1'b0;
    step   = 1'b0;
    finish = 1'b0;
    case (state)
      ipid_pkg::DIV_IDLE: begin
        load = req.start;
      end
      ipid_pkg::DIV_RUN: begin
        step = 1'b1;
      end
      ipid_pkg::DIV_SIGN: begin
        finish = 1'b1;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipid_pkg::DIV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[ipid_pkg::DIV_W-1];
      if (req.half) begin
        cnt   <= ipid_pkg::STEPS_HALF;
        shreg <= {mag[ipid_pkg::DIV_HALF-1:0], {ipid_pkg::DIV_HALF{1'b0}}};
      end else begin
        cnt   <= ipid_pkg::STEPS_FULL;
        shreg <= mag;
      end
    end
    if (step) begin
      rem   <= fits ? diff[ipid_pkg::DVS_W-1:0] : part[ipid_pkg::DVS_W-1:0];
      shreg <= {shreg[ipid_pkg::DIV_W-2:0], fits};
      cnt   <= cnt - 1'b1;
    end
    if (finish) begin
      quo <= neg ? -$signed(shreg) : $signed(shreg);
    end
  end

endmodule

// ===== design/ipid_mul.sv =====
`timescale 1ns / 1ps
// module: shared signed multiplier with registered product
module ipid_mul (
  input  logic                                  clk,
  input  logic signed [ipid_pkg::MUL_A_W-1:0]   a,
  input  logic signed [ipid_pkg::MUL_B_W-1:0]   b,
  output logic signed [ipid_pkg::MUL_P_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== design/ipid_core.sv =====
`timescale 1ns / 1ps
// module: pid sequencer and datapath around the shared multiplier and divider
module ipid_core #(
  parameter int PROP_DIVISOR  = 1,
  parameter int DERIV_DIVISOR = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ipid_pkg::cfg_t                        cfg,
  input  logic                                  take,
  input  logic signed [ipid_pkg::MEAS_W-1:0]    measurement,
  input  logic [ipid_pkg::DT_W-1:0]             elapsed,
  input  logic                                  out_free,
  output logic                                  busy,
  output logic                                  res_valid,
  output logic signed [ipid_pkg::DRIVE_W-1:0]   res
);

  localparam logic [ipid_pkg::DVS_W-1:0] FP =
    (PROP_DIVISOR < 1) ? 16'd1 : ipid_pkg::DVS_W'(PROP_DIVISOR);
  localparam logic [ipid_pkg::DVS_W-1:0] FD =
    (DERIV_DIVISOR < 1) ? 16'd1 : ipid_pkg::DVS_W'(DERIV_DIVISOR);

  ipid_pkg::core_state_t state, state_next;

  logic                                  first;
  logic signed [ipid_pkg::INT_W-1:0]     integ;
  logic signed [ipid_pkg::ERR_W-1:0]     prev_err;
  logic signed [ipid_pkg::MEAS_W-1:0]    meas;
  logic [ipid_pkg::DT_W-1:0]             dt;
  logic signed [ipid_pkg::ERR_W-1:0]     err;
  logic signed [ipid_pkg::SUM_W-1:0]     isum;
  logic                                  clamp_hi;
  logic signed [ipid_pkg::DER_W-1:0]     deriv;
  logic signed [ipid_pkg::DIV_W-1:0]     wide;
  logic signed [ipid_pkg::ACC_W-1:0]     acc;

  logic signed [ipid_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [ipid_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [ipid_pkg::MUL_P_W-1:0]   prod;
  ipid_pkg::div_req_t                    div_req;
  logic signed [ipid_pkg::DIV_W-1:0]     div_dividend;
  logic [ipid_pkg::DVS_W-1:0]            div_divisor;
  logic                                  div_done;
  logic signed [ipid_pkg::DIV_W-1:0]     div_quo;

  logic [ipid_pkg::DVS_W-1:0]            fi;
  logic signed [ipid_pkg::SUM_W-1:0]     q;
  logic                                  q_above, q_below;
  logic signed [ipid_pkg::DER_W-1:0]     err_diff;
  logic                                  acc_above, acc_below;

  ipid_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ipid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo)
  );

  assign fi        = (cfg.integ_divisor == '0) ? ipid_pkg::INTEG_DIV_RST : cfg.integ_divisor;
  assign q         = div_quo[ipid_pkg::SUM_W-1:0];
  assign q_above   = q > ipid_pkg::SUM_W'(cfg.upper_limit);
  assign q_below   = q < ipid_pkg::SUM_W'(cfg.lower_limit);
  assign err_diff  = ipid_pkg::DER_W'(err) - ipid_pkg::DER_W'(prev_err);
  assign acc_above = acc > ipid_pkg::ACC_W'(cfg.upper_limit);
  assign acc_below = acc < ipid_pkg::ACC_W'(cfg.lower_limit);

  always_comb begin
    state_next = state;
    case (state)
      ipid_pkg::S_IDLE: begin
        if (take) state_next = first ? ipid_pkg::S_OUT : ipid_pkg::S_FB_MUL;
      end
      ipid_pkg::S_FB_MUL:  state_next = ipid_pkg::S_FB_DIV;
      ipid_pkg::S_FB_DIV:  state_next = ipid_pkg::S_FB_WAIT;
      ipid_pkg::S_FB_WAIT: begin
        if (div_done) state_next = ipid_pkg::S_INT_MUL;
      end
      ipid_pkg::S_INT_MUL: state_next = ipid_pkg::S_INT_ADD;
      ipid_pkg::S_INT_ADD: state_next = ipid_pkg::S_INT_DIV;
      ipid_pkg::S_INT_DIV: state_next = ipid_pkg::S_INT_WAIT;
      ipid_pkg::S_INT_WAIT: begin
        if (div_done) begin
          state_next = (q_above || q_below) ? ipid_pkg::S_CLAMP_MUL : ipid_pkg::S_DER_DIV;
        end
      end
      ipid_pkg::S_CLAMP_MUL: state_next = ipid_pkg::S_CLAMP_SET;
      ipid_pkg::S_CLAMP_SET: state_next = ipid_pkg::S_DER_DIV;
      ipid_pkg::S_DER_DIV: begin
        state_next = (dt == '0) ? ipid_pkg::S_P_MUL : ipid_pkg::S_DER_WAIT;
      end
      ipid_pkg::S_DER_WAIT: begin
        if (div_done) state_next = ipid_pkg::S_P_MUL;
      end
      ipid_pkg::S_P_MUL:   state_next = ipid_pkg::S_P_DIV;
      ipid_pkg::S_P_DIV:   state_next = ipid_pkg::S_P_WAIT;
      ipid_pkg::S_P_WAIT: begin
        if (div_done) state_next = ipid_pkg::S_I_MUL_HI;
      end
      ipid_pkg::S_I_MUL_HI: state_next = ipid_pkg::S_I_MUL_LO;
      ipid_pkg::S_I_MUL_LO: state_next = ipid_pkg::S_I_SUM;
      ipid_pkg::S_I_SUM:    state_next = ipid_pkg::S_I_DIV;
      ipid_pkg::S_I_DIV:    state_next = ipid_pkg::S_I_WAIT;
      ipid_pkg::S_I_WAIT: begin
        if (div_done) state_next = ipid_pkg::S_D_MUL;
      end
      ipid_pkg::S_D_MUL:   state_next = ipid_pkg::S_D_DIV;
      ipid_pkg::S_D_DIV:   state_next = ipid_pkg::S_D_WAIT;
      ipid_pkg::S_D_WAIT: begin
        if (div_done) state_next = ipid_pkg::S_SAT;
      end
      ipid_pkg::S_SAT:     state_next = ipid_pkg::S_OUT;
      ipid_pkg::S_OUT: begin
        if (out_free) state_next = ipid_pkg::S_IDLE;
      end
      default: state_next = ipid_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != ipid_pkg::S_IDLE);
    res_valid    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_req      = '0;
    div_dividend = ipid_pkg::DIV_W'(prod);
    div_divisor  = fi;
    case (state)
      ipid_pkg::S_FB_MUL: begin
        mul_a = ipid_pkg::MUL_A_W'(meas);
        mul_b = ipid_pkg::MUL_B_W'(cfg.feedback_gain);
      end
      ipid_pkg::S_FB_DIV: begin
        div_req.start = 1'b1;
        div_req.half  = 1'b1;
        div_divisor   = ipid_pkg::PERCENT;
      end
      ipid_pkg::S_INT_MUL: begin
        mul_a = ipid_pkg::MUL_A_W'(err);
        mul_b = ipid_pkg::MUL_B_W'(dt);
      end
      ipid_pkg::S_INT_DIV: begin
        div_req.start = 1'b1;
        div_dividend  = ipid_pkg::DIV_W'(isum);
      end
      ipid_pkg::S_CLAMP_MUL: begin
        mul_a = clamp_hi ? ipid_pkg::MUL_A_W'(cfg.upper_limit)
                         : ipid_pkg::MUL_A_W'(cfg.lower_limit);
        mul_b = ipid_pkg::MUL_B_W'(fi);
      end
      ipid_pkg::S_DER_DIV: begin
        div_req.start = (dt != '0);
        div_req.half  = 1'b1;
        div_dividend  = ipid_pkg::DIV_W'(err_diff);
        div_divisor   = dt;
      end
      ipid_pkg::S_P_MUL: begin
        mul_a = ipid_pkg::MUL_A_W'(err);
        mul_b = ipid_pkg::MUL_B_W'(cfg.prop_gain);
      end
      ipid_pkg::S_P_DIV: begin
        div_req.start = 1'b1;
        div_divisor   = FP;
      end
      ipid_pkg::S_I_MUL_HI: begin
        mul_a = ipid_pkg::MUL_A_W'($signed(integ[ipid_pkg::INT_W-1:ipid_pkg::SPLIT]));
        mul_b = ipid_pkg::MUL_B_W'(cfg.integ_gain);
      end
      ipid_pkg::S_I_MUL_LO: begin
        mul_a = ipid_pkg::MUL_A_W'(integ[ipid_pkg::SPLIT-1:0]);
        mul_b = ipid_pkg::MUL_B_W'(cfg.integ_gain);
      end
      ipid_pkg::S_I_DIV: begin
        div_req.start = 1'b1;
        div_dividend  = wide;
      end
      ipid_pkg::S_D_MUL: begin
        mul_a = ipid_pkg::MUL_A_W'(deriv);
        mul_b = ipid_pkg::MUL_B_W'(cfg.deriv_gain);
      end
      ipid_pkg::S_D_DIV: begin
        div_req.start = 1'b1;
        div_divisor   = FD;
      end
      ipid_pkg::S_OUT: begin
        res_valid = out_free;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ipid_pkg::S_IDLE;
      first    <= 1'b1;
      integ    <= '0;
      prev_err <= '0;
    end else begin
      state <= state_next;
      if (state == ipid_pkg::S_IDLE && take) first <= 1'b0;
      if (state == ipid_pkg::S_INT_WAIT && div_done && !(q_above || q_below)) begin
        integ <= isum[ipid_pkg::INT_W-1:0];
      end
      if (state == ipid_pkg::S_CLAMP_SET) integ <= prod[ipid_pkg::INT_W-1:0];
      if (state == ipid_pkg::S_DER_DIV) prev_err <= err;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ipid_pkg::S_IDLE: begin
        if (take) begin
          meas <= measurement;
          dt   <= elapsed;
          res  <= ipid_pkg::DRIVE_W'(cfg.setpoint);
        end
      end
      ipid_pkg::S_FB_WAIT: begin
        if (div_done) err <= ipid_pkg::ERR_W'(cfg.setpoint) - div_quo[ipid_pkg::ERR_W-1:0];
      end
      ipid_pkg::S_INT_ADD: begin
        isum <= ipid_pkg::SUM_W'(integ) + prod[ipid_pkg::SUM_W-1:0];
      end
      ipid_pkg::S_INT_WAIT: begin
        if (div_done) clamp_hi <= q_above;
      end
      ipid_pkg::S_DER_DIV: begin
        if (dt == '0) deriv <= '0;
      end
      ipid_pkg::S_DER_WAIT: begin
        if (div_done) deriv <= div_quo[ipid_pkg::DER_W-1:0];
      end
      ipid_pkg::S_P_WAIT: begin
        if (div_done) acc <= div_quo[ipid_pkg::ACC_W-1:0];
      end
      ipid_pkg::S_I_MUL_LO: begin
        wide <= {prod[ipid_pkg::DIV_W-ipid_pkg::SPLIT-1:0], {ipid_pkg::SPLIT{1'b0}}};
      end
      ipid_pkg::S_I_SUM: begin
        wide <= wide + ipid_pkg::DIV_W'(prod);
      end
      ipid_pkg::S_I_WAIT, ipid_pkg::S_D_WAIT: begin
        if (div_done) acc <= acc + div_quo[ipid_pkg::ACC_W-1:0];
      end
      ipid_pkg::S_SAT: begin
        if (acc_above) begin
          res <= cfg.upper_limit;
        end else if (acc_below) begin
          res <= cfg.lower_limit;
        end else begin
          res <= acc[ipid_pkg::DRIVE_W-1:0];
        end
      end
      default: begin
        res <= res;
      end
    endcase
  end

endmodule

// ===== design/integer_pid_controller.sv =====
`timescale 1ns / 1ps
// top level: integer pid controller with integrator anti-windup
//
// One sample word (measurement, elapsed) in gives one drive word out. The first
// sample after reset returns the setpoint; every later sample makes six passes
// through the one shared restoring divider (the derivative pass is skipped when
// elapsed is zero) at one quotient bit per cycle, with a single shared 33x18
// multiplier. The block takes one sample at a time and holds sample_stall high
// until its drive word has gone into the output register; a finished drive word
// waits there, so the next sample is taken while it is not yet read. The user must
// write configuration through cfg_wen/cfg_index/cfg_data only while no sample is
// in flight; the block itself does not enforce this.
module integer_pid_controller #(
  parameter int PROP_DIVISOR  = 1,
  parameter int DERIV_DIVISOR = 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wen,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    sample_valid,
  output logic                                    sample_stall,
  input  logic signed [ipid_pkg::MEAS_W-1:0]      measurement,
  input  logic [ipid_pkg::DT_W-1:0]               elapsed,
  output logic                                    drive_valid,
  input  logic                                    drive_stall,
  output logic signed [ipid_pkg::DRIVE_W-1:0]     drive
);

  ipid_pkg::cfg_t                        cfg;
  logic                                  busy;
  logic                                  take;
  logic                                  out_free;
  logic                                  res_valid;
  logic signed [ipid_pkg::DRIVE_W-1:0]   res;

  assign sample_stall = busy;
  assign take         = sample_valid && !sample_stall;
  assign out_free     = !drive_valid || !drive_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint      <= '0;
      cfg.lower_limit   <= '0;
      cfg.upper_limit   <= '0;
      cfg.prop_gain     <= '0;
      cfg.integ_gain    <= '0;
      cfg.deriv_gain    <= '0;
      cfg.integ_divisor <= ipid_pkg::INTEG_DIV_RST;
      cfg.feedback_gain <= ipid_pkg::FEEDBACK_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        ipid_pkg::REG_SETPOINT:      cfg.setpoint      <= cfg_data[ipid_pkg::SP_W-1:0];
        ipid_pkg::REG_LOWER_LIMIT:   cfg.lower_limit   <= cfg_data[ipid_pkg::LIM_W-1:0];
        ipid_pkg::REG_UPPER_LIMIT:   cfg.upper_limit   <= cfg_data[ipid_pkg::LIM_W-1:0];
        ipid_pkg::REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_INTEG_GAIN:    cfg.integ_gain    <= cfg_data[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_DERIV_GAIN:    cfg.deriv_gain    <= cfg_data[ipid_pkg::GAIN_W-1:0];
        ipid_pkg::REG_INTEG_DIVISOR: cfg.integ_divisor <= cfg_data[ipid_pkg::DVS_W-1:0];
        ipid_pkg::REG_FEEDBACK_GAIN: cfg.feedback_gain <= cfg_data[ipid_pkg::FB_W-1:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  ipid_core #(
    .PROP_DIVISOR  (PROP_DIVISOR),
    .DERIV_DIVISOR (DERIV_DIVISOR)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .measurement (measurement),
    .elapsed     (elapsed),
    .out_free    (out_free),
    .busy        (busy),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (res_valid) begin
      drive_valid <= 1'b1;
    end else if (drive_valid && !drive_stall) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) drive <= res;
  end

endmodule

// ===== design/ipid_check.sv =====
`timescale 1ns / 1ps
// checker: port-level properties of the integer pid controller, bound to the top
module ipid_check (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  cfg_wen,
  input logic [ipid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input logic [ipid_pkg::CFG_DATA_W-1:0]       cfg_data,
  input logic                                  sample_valid,
  input logic                                  sample_stall,
  input logic signed [ipid_pkg::MEAS_W-1:0]    measurement,
  input logic [ipid_pkg::DT_W-1:0]             elapsed,
  input logic                                  drive_valid,
  input logic                                  drive_stall,
  input logic signed [ipid_pkg::DRIVE_W-1:0]   drive
);

  // an accepted sample keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("sample taken but block not busy");

  // a stalled drive word holds
  a_drive_hold: assert property (@(posedge clk) disable iff (rst)
    (drive_valid && drive_stall) |=> (drive_valid && $stable(drive)))
    else $error("stalled drive word changed");

  // no drive word right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !drive_valid)
    else $error("drive valid after reset");

  // a new drive word only comes out of work in progress
  a_word_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(drive_valid) |-> $past(sample_stall))
    else $error("drive word without a sample in progress");

endmodule

bind integer_pid_controller ipid_check u_check (.*);

// ===== test/tb_integer_pid_controller.sv =====
`timescale 1ns / 1ps
// testbench: integer pid controller checked word by word against a built-in predictor
module tb_integer_pid_controller;

  localparam int PROP_DIV  = 1;
  localparam int DERIV_DIV = 1;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_wen = 1'b0;
  logic [ipid_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [ipid_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                 sample_valid = 1'b0;
  logic                                 sample_stall;
  logic signed [ipid_pkg::MEAS_W-1:0]   measurement = '0;
  logic [ipid_pkg::DT_W-1:0]            elapsed = '0;
  logic                                 drive_valid;
  logic                                 drive_stall = 1'b0;
  logic signed [ipid_pkg::DRIVE_W-1:0]  drive;

  // controller copy used for prediction
  longint cfg_sp, cfg_lo, cfg_hi, cfg_kp, cfg_ki, cfg_kd, cfg_fi, cfg_fb;
  bit     model_first;
  longint model_integral;
  longint model_prev_err;

  logic signed [ipid_pkg::DRIVE_W-1:0] drive_expected[$];
  logic signed [ipid_pkg::DRIVE_W-1:0] drive_want;
  int failures = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  integer_pid_controller #(
    .PROP_DIVISOR (PROP_DIV),
    .DERIV_DIVISOR(DERIV_DIV)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .measurement (measurement),
    .elapsed     (elapsed),
    .drive_valid (drive_valid),
    .drive_stall (drive_stall),
    .drive       (drive)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic signed [ipid_pkg::DRIVE_W-1:0] pid_predict(
      logic signed [ipid_pkg::MEAS_W-1:0] meas, logic [ipid_pkg::DT_W-1:0] dt_in);
    longint m, dt, fi, fp, fd, err, q, deriv, acc;
    m  = longint'(meas);
    dt = longint'(dt_in);
    fi = (cfg_fi < 1) ? 1 : cfg_fi;
    fp = (PROP_DIV < 1) ? 1 : PROP_DIV;
    fd = (DERIV_DIV < 1) ? 1 : DERIV_DIV;
    if (model_first) begin
      model_first = 1'b0;
      return cfg_sp[ipid_pkg::DRIVE_W-1:0];
    end
    err = cfg_sp - (m * cfg_fb) / 100;
    model_integral = model_integral + err * dt;
    q = model_integral / fi;
    if (q > cfg_hi) begin
      model_integral = cfg_hi * fi;
    end else if (q < cfg_lo) begin
      model_integral = cfg_lo * fi;
    end
    deriv = (dt == 0) ? 0 : (err - model_prev_err) / dt;
    model_prev_err = err;
    acc = (cfg_kp * err) / fp + (cfg_ki * model_integral) / fi + (cfg_kd * deriv) / fd;
    if (acc > cfg_hi) begin
      acc = cfg_hi;
    end else if (acc < cfg_lo) begin
      acc = cfg_lo;
    end
    return acc[ipid_pkg::DRIVE_W-1:0];
  endfunction

  // result check and prediction on accepted sample words
  always @(posedge clk) begin
    if (!rst) begin
      if (drive_valid && !drive_stall) begin
        if (drive_expected.size() == 0) begin
          $error("drive: expected none, actual %0d", drive);
          failures++;
        end else begin
          drive_want = drive_expected.pop_front();
          if (drive !== drive_want) begin
            $error("drive: expected %0d, actual %0d", drive_want, drive);
            failures++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        drive_expected.push_back(pid_predict(measurement, elapsed));
      end
    end
  end

  // receiver stall, with long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      drive_stall <= 1'b1;
    end else begin
      drive_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                           logic [ipid_pkg::CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      ipid_pkg::REG_SETPOINT:
        cfg_sp = longint'(signed'(data[ipid_pkg::SP_W-1:0]));
      ipid_pkg::REG_LOWER_LIMIT:
        cfg_lo = longint'(signed'(data[ipid_pkg::LIM_W-1:0]));
      ipid_pkg::REG_UPPER_LIMIT:
        cfg_hi = longint'(signed'(data[ipid_pkg::LIM_W-1:0]));
      ipid_pkg::REG_PROP_GAIN:
        cfg_kp = longint'(signed'(data[ipid_pkg::GAIN_W-1:0]));
      ipid_pkg::REG_INTEG_GAIN:
        cfg_ki = longint'(signed'(data[ipid_pkg::GAIN_W-1:0]));
      ipid_pkg::REG_DERIV_GAIN:
        cfg_kd = longint'(signed'(data[ipid_pkg::GAIN_W-1:0]));
      ipid_pkg::REG_INTEG_DIVISOR:
        cfg_fi = longint'(data[ipid_pkg::DVS_W-1:0]);
      ipid_pkg::REG_FEEDBACK_GAIN:
        cfg_fb = longint'(data[ipid_pkg::FB_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(logic [31:0] sp, logic [31:0] lo, logic [31:0] hi, logic [31:0] kp,
                             logic [31:0] ki, logic [31:0] kd, logic [31:0] fi,
                             logic [31:0] fb);
    write_reg(ipid_pkg::REG_SETPOINT, sp);
    write_reg(ipid_pkg::REG_LOWER_LIMIT, lo);
    write_reg(ipid_pkg::REG_UPPER_LIMIT, hi);
    write_reg(ipid_pkg::REG_PROP_GAIN, kp);
    write_reg(ipid_pkg::REG_INTEG_GAIN, ki);
    write_reg(ipid_pkg::REG_DERIV_GAIN, kd);
    write_reg(ipid_pkg::REG_INTEG_DIVISOR, fi);
    write_reg(ipid_pkg::REG_FEEDBACK_GAIN, fb);
  endtask

  task automatic offer_sample(logic signed [ipid_pkg::MEAS_W-1:0] m,
                              logic [ipid_pkg::DT_W-1:0] dt);
    int gap;
    gap = 0;
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) gap++;
      if ($urandom_range(7) == 0) gap += $urandom_range(1, 400);
    end
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    measurement  <= m;
    elapsed      <= dt;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic wait_quiet();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_first_sample();
    wait_quiet();
    load_config(32'hFFFF_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5, 32'd3, 32'd2,
                32'd10, 32'd100);
    offer_sample(16'sh7FFF, 16'hFFFF);
  endtask

  task automatic test_field_extremes();
    logic signed [ipid_pkg::MEAS_W-1:0] meas_set[3];
    logic [ipid_pkg::DT_W-1:0]          dt_set[3];
    meas_set = '{16'sh8000, 16'sh7FFF, 16'sh0000};
    dt_set   = '{16'h0000, 16'h0001, 16'hFFFF};
    wait_quiet();
    load_config(32'h0000_7FFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_7FFF,
                32'hFFFF_8000, 32'h0000_7FFF, 32'h0000_FFFF, 32'd1023);
    foreach (meas_set[i]) begin
      foreach (dt_set[j]) offer_sample(meas_set[i], dt_set[j]);
    end
  endtask

  task automatic test_zero_divisor();
    wait_quiet();
    load_config(32'hFFFF_8000, 32'hFFF0_0000, 32'h000F_FFFF, 32'hFFFF_8000, 32'h0000_7FFF,
                32'hFFFF_8000, 32'd0, 32'd0);
    offer_sample(16'sh1234, 16'd7);
    offer_sample(-16'sd300, 16'd0);
    offer_sample(16'sh7FFF, 16'd3);
  endtask

  task automatic test_crossed_limits();
    wait_quiet();
    load_config(32'd200, 32'd1000, -32'sd1000, 32'd40, 32'd7, 32'd9, 32'd3, 32'd150);
    offer_sample(16'sd0, 16'd5);
    offer_sample(16'sd2000, 16'd5);
    offer_sample(-16'sd2000, 16'd1);
    offer_sample(16'sd130, 16'd0);
  endtask

  task automatic test_integrator_windup();
    wait_quiet();
    load_config(32'd1000, -32'sd500, 32'd500, 32'd0, 32'd1, 32'd0, 32'd1, 32'd100);
    repeat (3) offer_sample(16'sd0, 16'd100);
    repeat (3) offer_sample(16'sd2000, 16'd60);
  endtask

  task automatic test_output_backpressure();
    wait_quiet();
    load_config(32'd77, -32'sd100000, 32'd100000, 32'd3, 32'd2, 32'd5, 32'd4, 32'd90);
    hold_req = 2000;
    offer_sample(16'sd10, 16'd2);
    offer_sample(-16'sd45, 16'd3);
    offer_sample(16'sd300, 16'd0);
    offer_sample(16'sd5, 16'd9);
  endtask

  task automatic test_sender_pause();
    offer_sample(16'sd100, 16'd4);
    offer_sample(-16'sd100, 16'd4);
    wait_quiet();
    offer_sample(16'sd50, 16'd1);
    offer_sample(16'sd60, 16'd2);
  endtask

  task automatic random_config();
    int unsigned r;
    logic [31:0] lo, hi, kp, ki, kd, fi, fb;
    r = $urandom_range(1, 200000);
    case ($urandom_range(3))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: begin
        lo = -r;
        hi = r;
      end
      2: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: begin
        lo = r;
        hi = -r;
      end
    endcase
    kp = $urandom_range(1) ? $urandom : 32'($urandom_range(128)) - 32'd64;
    ki = $urandom_range(1) ? $urandom : 32'($urandom_range(128)) - 32'd64;
    kd = $urandom_range(1) ? $urandom : 32'($urandom_range(128)) - 32'd64;
    case ($urandom_range(4))
      0: fi = 32'd0;
      1: fi = 32'd1;
      2: fi = 32'h0000_FFFF;
      3: fi = $urandom_range(1, 1000);
      default: fi = $urandom;
    endcase
    case ($urandom_range(3))
      0: fb = 32'd0;
      1: fb = 32'd100;
      2: fb = 32'd1023;
      default: fb = $urandom_range(1023);
    endcase
    load_config($urandom, lo, hi, kp, ki, kd, fi, fb);
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    logic signed [ipid_pkg::MEAS_W-1:0] m;
    logic [ipid_pkg::DT_W-1:0]          dt;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        wait_quiet();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        random_config();
      end
      case ($urandom_range(7))
        0: m = 16'sh8000;
        1: m = 16'sh7FFF;
        2: m = $urandom_range(1) ? 16'sh0000 : 16'(signed'($urandom_range(200)) - 100);
        default: m = $urandom;
      endcase
      case ($urandom_range(19))
        0, 1: dt = 16'd0;
        2: dt = 16'hFFFF;
        3, 4, 5, 6, 7, 8, 9, 10, 11, 12: dt = $urandom_range(1, 20);
        default: dt = $urandom;
      endcase
      offer_sample(m, dt);
    end
  endtask

  initial begin
    cfg_sp = 0;
    cfg_lo = 0;
    cfg_hi = 0;
    cfg_kp = 0;
    cfg_ki = 0;
    cfg_kd = 0;
    cfg_fi = 1;
    cfg_fb = 100;
    model_first = 1'b1;
    model_integral = 0;
    model_prev_err = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 9;
    recv_idle_pct = 68;
    test_first_sample();
    test_field_extremes();
    test_zero_divisor();
    test_crossed_limits();
    test_integrator_windup();
    test_output_backpressure();
    test_sender_pause();
    test_random(670, 9, 68);
    test_random(670, 68, 9);
    test_random(670, 0, 0);
    wait_quiet();
    repeat (400) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
